// ----- hw/rtl/ewt_pkg.sv -----
`default_nettype none
package ewt_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EP_W = 32;

  localparam logic [2:0] CMD_WATCH  = 3'd0;
  localparam logic [2:0] CMD_WAIT   = 3'd1;
  localparam logic [2:0] CMD_CANCEL = 3'd2;
  localparam logic [2:0] CMD_QUERY  = 3'd3;
  localparam logic [2:0] CMD_DIED   = 3'd4;
  localparam logic [2:0] CMD_SIGNAL = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DENIED   = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NONE     = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_WAKE   = 2'd1;
  localparam logic [1:0] KIND_NOTIFY = 2'd2;
  localparam logic [1:0] KIND_INTR   = 2'd3;

  typedef logic [EP_W-1:0] ep_t;
endpackage
`default_nettype wire

// ----- hw/rtl/exit_watch_table_top.sv -----
// Each entry scanned is a RAM read, then a compare; a deletion adds a tail move (read,
//   then write), and a result is loaded into the output register; a death emits results
//   as it scans. One transaction at a time; in_ready is high only between commands. A
//   wait with free space is written without leaving idle. An out_ready stall holds a
//   command in its emit or flush state, or a death in its compare state.
// Reset: synchronous active-low rst_n clears both counts, sequencer and output valid.
`default_nettype none
module exit_watch_table_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      in_command,
  input  wire ewt_pkg::ep_t    in_caller,
  input  wire ewt_pkg::ep_t    in_target,
  input  wire logic            in_caller_privileged,
  input  wire logic            in_registration_ok,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           out_kind,
  output ewt_pkg::ep_t         out_destination,
  output logic [2:0]           out_status,
  output ewt_pkg::ep_t         out_reported_process,
  output logic [6:0]           out_remaining_count,
  output logic                 out_last
);
  import ewt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_MVRD  = 3'd3;
  localparam logic [2:0] S_MVWR  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  ep_t              caller_r, caller_nxt, target_r, target_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, wc_r, wc_nxt, ec_r, ec_nxt;
  logic [CNT_W-1:0] found_r, found_nxt, first_r, first_nxt;
  ep_t              rep_r, rep_nxt;
  logic [6:0]       rem_r, rem_nxt;
  logic [2:0]       status_r, status_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [1:0]       pend_kind_r, pend_kind_nxt;
  ep_t              pend_dest_r, pend_dest_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  ep_t              out_dest_r, out_dest_nxt, out_rep_r, out_rep_nxt;
  logic [2:0]       out_status_r, out_status_nxt;
  logic [6:0]       out_rem_r, out_rem_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_free, in_acc;
  logic [CNT_W-1:0] wtail, etail, remc;
  logic             w_we, e_we;
  logic [IDX_W-1:0] w_waddr, w_raddr, e_waddr, e_raddr;
  logic [2*EP_W:0]  w_wdata, w_rdata;
  logic [2*EP_W-1:0] e_wdata, e_rdata;
  ep_t              w_obs, w_tgt, e_obs, e_tgt;
  logic             w_blk;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign wtail = wc_r - 1'b1;
  assign etail = ec_r - 1'b1;
  assign remc = found_r - 1'b1;
  assign {w_blk, w_obs, w_tgt} = w_rdata;
  assign {e_obs, e_tgt} = e_rdata;
  assign w_raddr = (state_r == S_MVRD) ? wtail[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign e_raddr = (state_r == S_MVRD) ? etail[IDX_W-1:0] : idx_r[IDX_W-1:0];

  ewt_ram #(.WIDTH(2*EP_W+1), .DEPTH(TABLE_DEPTH)) u_watch (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  ewt_ram #(.WIDTH(2*EP_W), .DEPTH(TABLE_DEPTH)) u_exit (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    caller_nxt = caller_r;
    target_nxt = target_r;
    idx_nxt = idx_r;
    wc_nxt = wc_r;
    ec_nxt = ec_r;
    found_nxt = found_r;
    first_nxt = first_r;
    rep_nxt = rep_r;
    rem_nxt = rem_r;
    status_nxt = status_r;
    pend_valid_nxt = pend_valid_r;
    pend_kind_nxt = pend_kind_r;
    pend_dest_nxt = pend_dest_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r;
    out_dest_nxt = out_dest_r;
    out_rep_nxt = out_rep_r;
    out_status_nxt = out_status_r;
    out_rem_nxt = out_rem_r;
    out_last_nxt = out_last_r;
    w_we = 1'b0;
    w_waddr = wc_r[IDX_W-1:0];
    w_wdata = {1'b0, caller_r, target_r};
    e_we = 1'b0;
    e_waddr = ec_r[IDX_W-1:0];
    e_wdata = {w_obs, w_tgt};

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_command;
          caller_nxt = in_caller;
          target_nxt = in_target;
          idx_nxt = '0;
          found_nxt = '0;
          first_nxt = '0;
          rep_nxt = '0;
          rem_nxt = '0;
          case (in_command)
            CMD_WATCH, CMD_CANCEL, CMD_QUERY: begin
              if (!in_caller_privileged) begin
                status_nxt = ST_DENIED;
                state_nxt = S_EMIT;
              end else if (in_command == CMD_WATCH && !in_registration_ok) begin
                status_nxt = ST_NONE;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_WAIT: begin
              if (!in_registration_ok) begin
                status_nxt = ST_NONE;
                state_nxt = S_EMIT;
              end else if (wc_r == FULL) begin
                status_nxt = ST_FULL;
                state_nxt = S_EMIT;
              end else begin
                w_we = 1'b1;
                w_wdata = {1'b1, in_caller, in_target};
                wc_nxt = wc_r + 1'b1;
              end
            end
            CMD_DIED, CMD_SIGNAL: state_nxt = S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (idx_r >= ((cmd_r == CMD_QUERY) ? ec_r : wc_r)) begin
          case (cmd_r)
            CMD_WATCH: begin
              if (wc_r == FULL) begin
                status_nxt = ST_FULL;
              end else begin
                w_we = 1'b1;
                wc_nxt = wc_r + 1'b1;
                status_nxt = ST_OK;
              end
              state_nxt = S_EMIT;
            end
            CMD_CANCEL: begin
              status_nxt = ST_NOTFOUND;
              state_nxt = S_EMIT;
            end
            CMD_QUERY: begin
              if (found_r == '0) begin
                status_nxt = ST_NONE;
                state_nxt = S_EMIT;
              end else begin
                status_nxt = ST_OK;
                rem_nxt = (32'(remc) > 32'd127) ? 7'd127 : 7'(remc);
                idx_nxt = first_r;
                if (first_r == etail) begin
                  ec_nxt = etail;
                  state_nxt = S_EMIT;
                end else begin
                  state_nxt = S_MVRD;
                end
              end
            end
            CMD_DIED: state_nxt = S_FLUSH;
            default: state_nxt = S_IDLE;
          endcase
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_RD;
        idx_nxt = idx_r + 1'b1;
        case (cmd_r)
          CMD_WATCH: begin
            if (w_obs == caller_r && w_tgt == target_r) begin
              status_nxt = ST_DUP;
              state_nxt = S_EMIT;
            end
          end
          CMD_CANCEL: begin
            if (w_obs == caller_r && w_tgt == target_r) begin
              status_nxt = ST_OK;
              idx_nxt = idx_r;
              if (idx_r == wtail) begin
                wc_nxt = wtail;
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_MVRD;
              end
            end
          end
          CMD_QUERY: begin
            if (e_obs == caller_r) begin
              if (found_r == '0) begin
                first_nxt = idx_r;
                rep_nxt = e_tgt;
              end
              found_nxt = found_r + 1'b1;
            end
          end
          CMD_SIGNAL: begin
            if (w_obs == target_r) begin
              status_nxt = ST_NONE;
              state_nxt = S_EMIT;
            end
          end
          CMD_DIED: begin
            if (w_tgt == target_r || w_obs == target_r) begin
              idx_nxt = idx_r;
              if (w_tgt == target_r && pend_valid_r && !out_free) begin
                state_nxt = S_CMP;
              end else begin
                if (w_tgt == target_r) begin
                  if (pend_valid_r) begin
                    out_valid_nxt = 1'b1;
                    out_kind_nxt = pend_kind_r;
                    out_dest_nxt = pend_dest_r;
                    out_status_nxt = ST_OK;
                    out_rep_nxt = target_r;
                    out_rem_nxt = '0;
                    out_last_nxt = 1'b0;
                  end
                  pend_valid_nxt = 1'b1;
                  pend_kind_nxt = w_blk ? KIND_WAKE : KIND_NOTIFY;
                  pend_dest_nxt = w_obs;
                  if (ec_r < FULL) begin
                    e_we = 1'b1;
                    ec_nxt = ec_r + 1'b1;
                  end
                end
                if (idx_r == wtail) begin
                  wc_nxt = wtail;
                end else begin
                  state_nxt = S_MVRD;
                end
              end
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MVRD: state_nxt = S_MVWR;
      S_MVWR: begin
        if (cmd_r == CMD_QUERY) begin
          e_we = 1'b1;
          e_waddr = idx_r[IDX_W-1:0];
          e_wdata = e_rdata;
          ec_nxt = etail;
          state_nxt = S_EMIT;
        end else begin
          w_we = 1'b1;
          w_waddr = idx_r[IDX_W-1:0];
          w_wdata = w_rdata;
          wc_nxt = wtail;
          state_nxt = (cmd_r == CMD_DIED) ? S_RD : S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = (cmd_r == CMD_SIGNAL) ? KIND_INTR : KIND_REPLY;
          out_dest_nxt = (cmd_r == CMD_SIGNAL) ? target_r : caller_r;
          out_status_nxt = status_r;
          out_rep_nxt = (status_r == ST_OK) ? rep_r : '0;
          out_rem_nxt = (status_r == ST_OK) ? rem_r : '0;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = pend_kind_r;
          out_dest_nxt = pend_dest_r;
          out_status_nxt = ST_OK;
          out_rep_nxt = target_r;
          out_rem_nxt = '0;
          out_last_nxt = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wc_r <= '0;
      ec_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wc_r <= wc_nxt;
      ec_r <= ec_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    caller_r <= caller_nxt;
    target_r <= target_nxt;
    idx_r <= idx_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    rep_r <= rep_nxt;
    rem_r <= rem_nxt;
    status_r <= status_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_dest_r <= pend_dest_nxt;
    out_kind_r <= out_kind_nxt;
    out_dest_r <= out_dest_nxt;
    out_rep_r <= out_rep_nxt;
    out_status_r <= out_status_nxt;
    out_rem_r <= out_rem_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_destination = out_dest_r;
  assign out_status = out_status_r;
  assign out_reported_process = out_rep_r;
  assign out_remaining_count = out_rem_r;
  assign out_last = out_last_r;

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n) wc_r <= FULL)
    else $error("watch count overflow");
  a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n) ec_r <= FULL)
    else $error("exit count overflow");
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_valid_r)
    else $error("pending result left behind");
  a_wc_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> wc_r <= $past(wc_r) + 1'b1)
    else $error("watch count jumped");
endmodule
`default_nettype wire

// ----- hw/rtl/ewt_ram.sv -----
`default_nettype none
module ewt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- verif/exit_watch_table_top_tb.sv -----
`default_nettype none
module exit_watch_table_top_tb;
  import ewt_pkg::*;

  localparam int MAX_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  ep_t in_caller = '0;
  ep_t in_target = '0;
  logic in_caller_privileged = 1'b0;
  logic in_registration_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  ep_t out_destination;
  logic [2:0] out_status;
  ep_t out_reported_process;
  logic [6:0] out_remaining_count;
  logic out_last;

  exit_watch_table_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_caller(in_caller), .in_target(in_target),
    .in_caller_privileged(in_caller_privileged),
    .in_registration_ok(in_registration_ok),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_destination(out_destination),
    .out_status(out_status), .out_reported_process(out_reported_process),
    .out_remaining_count(out_remaining_count), .out_last(out_last)
  );

  always #6 clk = ~clk;

  typedef struct packed {
    logic [1:0] kind;
    ep_t dest;
    logic [2:0] status;
    ep_t reported;
    logic [6:0] remaining;
    logic last;
  } notice_t;

  typedef struct {
    logic [2:0] cmd;
    ep_t caller;
    ep_t target;
    logic priv;
    logic reg_ok;
    logic has_fixed;
    notice_t fixed;
  } cmd_row_t;

  // watcher model
  ep_t w_obs[$];
  ep_t w_tgt[$];
  logic w_blk[$];
  ep_t x_obs[$];
  ep_t x_tgt[$];

  notice_t pending_notices[$];
  int n_errors = 0;
  int n_results = 0;
  int n_commands = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic done = 1'b0;

  ep_t pool[8];

  function automatic notice_t mk(logic [1:0] k, ep_t d, logic [2:0] s, ep_t r,
                                 logic [6:0] rem);
    notice_t n;
    n.kind = k; n.dest = d; n.status = s; n.reported = r; n.remaining = rem;
    n.last = 1'b0;
    return n;
  endfunction

  task automatic predict_command(input logic [2:0] cmd, input ep_t caller,
                                 input ep_t target, input logic priv,
                                 input logic reg_ok);
    notice_t outs[$];
    logic [2:0] st;
    int found;
    int first;
    int i;
    case (cmd)
      CMD_WATCH: begin
        st = ST_OK;
        if (!priv) st = ST_DENIED;
        else if (!reg_ok) st = ST_NONE;
        else begin
          for (i = 0; i < w_obs.size(); i++)
            if (w_obs[i] == caller && w_tgt[i] == target) st = ST_DUP;
          if (st == ST_OK) begin
            if (w_obs.size() >= TABLE_DEPTH) st = ST_FULL;
            else begin
              w_obs.push_back(caller); w_tgt.push_back(target); w_blk.push_back(1'b0);
            end
          end
        end
        outs.push_back(mk(KIND_REPLY, caller, st, '0, '0));
      end
      CMD_WAIT: begin
        if (!reg_ok) outs.push_back(mk(KIND_REPLY, caller, ST_NONE, '0, '0));
        else if (w_obs.size() >= TABLE_DEPTH)
          outs.push_back(mk(KIND_REPLY, caller, ST_FULL, '0, '0));
        else begin
          w_obs.push_back(caller); w_tgt.push_back(target); w_blk.push_back(1'b1);
        end
      end
      CMD_CANCEL: begin
        st = ST_NOTFOUND;
        if (!priv) st = ST_DENIED;
        else begin
          for (i = 0; i < w_obs.size(); i++)
            if (w_obs[i] == caller && w_tgt[i] == target) begin
              w_obs[i] = w_obs[$]; w_tgt[i] = w_tgt[$]; w_blk[i] = w_blk[$];
              void'(w_obs.pop_back()); void'(w_tgt.pop_back()); void'(w_blk.pop_back());
              st = ST_OK;
              break;
            end
        end
        outs.push_back(mk(KIND_REPLY, caller, st, '0, '0));
      end
      CMD_QUERY: begin
        if (!priv) outs.push_back(mk(KIND_REPLY, caller, ST_DENIED, '0, '0));
        else begin
          found = 0; first = 0;
          for (i = 0; i < x_obs.size(); i++)
            if (x_obs[i] == caller) begin
              if (found == 0) first = i;
              found++;
            end
          if (found == 0) outs.push_back(mk(KIND_REPLY, caller, ST_NONE, '0, '0));
          else begin
            outs.push_back(mk(KIND_REPLY, caller, ST_OK, x_tgt[first], 7'(found - 1)));
            x_obs[first] = x_obs[$]; x_tgt[first] = x_tgt[$];
            void'(x_obs.pop_back()); void'(x_tgt.pop_back());
          end
        end
      end
      CMD_DIED: begin
        i = 0;
        while (i < w_obs.size()) begin
          if (w_tgt[i] == target || w_obs[i] == target) begin
            if (w_tgt[i] == target) begin
              outs.push_back(mk(w_blk[i] ? KIND_WAKE : KIND_NOTIFY, w_obs[i], ST_OK,
                                target, '0));
              if (x_obs.size() < TABLE_DEPTH) begin
                x_obs.push_back(w_obs[i]); x_tgt.push_back(w_tgt[i]);
              end
            end
            w_obs[i] = w_obs[$]; w_tgt[i] = w_tgt[$]; w_blk[i] = w_blk[$];
            void'(w_obs.pop_back()); void'(w_tgt.pop_back()); void'(w_blk.pop_back());
          end else i++;
        end
      end
      CMD_SIGNAL: begin
        for (i = 0; i < w_obs.size(); i++)
          if (w_obs[i] == target) begin
            outs.push_back(mk(KIND_INTR, target, ST_NONE, '0, '0));
            break;
          end
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[$].last = 1'b1;
    foreach (outs[j]) pending_notices.push_back(outs[j]);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("MISMATCH at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    notice_t w;
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_notices.size() == 0) report_mismatch("unexpected transaction", 0, 0);
      else begin
        w = pending_notices.pop_front();
        if (out_kind !== w.kind) report_mismatch("kind", out_kind, w.kind);
        if (out_destination !== w.dest) report_mismatch("destination", out_destination, w.dest);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_reported_process !== w.reported)
          report_mismatch("reported_process", out_reported_process, w.reported);
        if (out_remaining_count !== w.remaining)
          report_mismatch("remaining_count", out_remaining_count, w.remaining);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  always @(negedge clk) begin
    if (done) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_command(input logic [2:0] cmd, input ep_t caller, input ep_t target,
                              input logic priv, input logic reg_ok);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd; in_caller <= caller; in_target <= target;
    in_caller_privileged <= priv; in_registration_ok <= reg_ok;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(cmd, caller, target, priv, reg_ok);
    n_commands++;
  endtask

  task automatic wait_empty;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_notices.size() != 0) @(negedge clk);
  endtask

  task automatic drain;
    wait_empty();
    repeat (400) @(negedge clk);
  endtask

  function automatic ep_t pick_ep();
    if ($urandom_range(9) < 8) return pool[$urandom_range(7)];
    return ep_t'($urandom);
  endfunction

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 25) return CMD_WATCH;
    if (r < 45) return CMD_WAIT;
    if (r < 57) return CMD_CANCEL;
    if (r < 72) return CMD_QUERY;
    if (r < 85) return CMD_DIED;
    if (r < 97) return CMD_SIGNAL;
    return 3'($urandom_range(7, 6));
  endfunction

  cmd_row_t rows[$];

  task automatic add_row(input logic [2:0] c, input ep_t a, input ep_t t, input logic p,
                         input logic r, input logic f, input notice_t n);
    cmd_row_t row;
    row.cmd = c; row.caller = a; row.target = t; row.priv = p; row.reg_ok = r;
    row.has_fixed = f; row.fixed = n;
    rows.push_back(row);
  endtask

  initial begin
    notice_t z;
    notice_t fx;
    int phase;
    int k;
    z = '0;
    pool[0] = 32'sh7FFF_FFFF; pool[1] = 32'sh8000_0000; pool[2] = 0; pool[3] = -1;
    pool[4] = 5; pool[5] = 17; pool[6] = 32'h5A5A_A5A5; pool[7] = 32'hA5A5_5A5A;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // after reset: empty tables
    fx = mk(KIND_REPLY, 5, ST_NOTFOUND, '0, '0); fx.last = 1;
    add_row(CMD_CANCEL, 5, 17, 1, 1, 1, fx);
    fx = mk(KIND_REPLY, 5, ST_NONE, '0, '0); fx.last = 1;
    add_row(CMD_QUERY, 5, 0, 1, 1, 1, fx);
    fx = mk(KIND_REPLY, 32'h7FFF_FFFF, ST_DENIED, '0, '0); fx.last = 1;
    add_row(CMD_WATCH, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1, fx);
    fx = mk(KIND_REPLY, 32'h8000_0000, ST_NONE, '0, '0); fx.last = 1;
    add_row(CMD_WATCH, 32'h8000_0000, 0, 1, 0, 1, fx);
    fx = mk(KIND_REPLY, 0, ST_NONE, '0, '0); fx.last = 1;
    add_row(CMD_WAIT, 0, 5, 0, 0, 1, fx);
    fx = mk(KIND_REPLY, 32'h7FFF_FFFF, ST_OK, '0, '0); fx.last = 1;
    add_row(CMD_WATCH, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1, fx);
    fx = mk(KIND_REPLY, 32'h7FFF_FFFF, ST_DUP, '0, '0); fx.last = 1;
    add_row(CMD_WATCH, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 1, fx);
    add_row(CMD_WAIT, 5, 32'h8000_0000, 0, 1, 0, z);
    add_row(CMD_WAIT, 5, 32'h8000_0000, 0, 1, 0, z);
    add_row(CMD_WAIT, 32'h8000_0000, 17, 0, 1, 0, z);
    add_row(CMD_SIGNAL, 0, 5, 0, 0, 0, z);
    add_row(CMD_SIGNAL, 0, 17, 0, 0, 0, z);
    add_row(CMD_DIED, 0, 32'h8000_0000, 0, 0, 0, z);
    fx = mk(KIND_REPLY, 5, ST_DENIED, '0, '0); fx.last = 1;
    add_row(CMD_QUERY, 5, 0, 0, 1, 1, fx);
    add_row(CMD_QUERY, 5, 0, 1, 0, 0, z);
    add_row(CMD_QUERY, 5, 0, 1, 0, 0, z);
    add_row(CMD_QUERY, 32'h7FFF_FFFF, 0, 1, 0, 0, z);
    fx = mk(KIND_REPLY, 3, ST_DENIED, '0, '0); fx.last = 1;
    add_row(CMD_CANCEL, 3, 3, 0, 1, 1, fx);
    add_row(CMD_WATCH, -1, -1, 1, 1, 0, z);
    add_row(CMD_CANCEL, -1, -1, 1, 0, 0, z);
    add_row(CMD_WAIT, -1, -1, 1, 1, 0, z);
    add_row(CMD_DIED, 0, -1, 1, 1, 0, z);
    add_row(3'd6, 1, 1, 1, 1, 0, z);
    add_row(3'd7, -2, -2, 0, 0, 0, z);

    foreach (rows[i]) begin
      if (rows[i].has_fixed) begin
        send_command(rows[i].cmd, rows[i].caller, rows[i].target, rows[i].priv,
                     rows[i].reg_ok);
        if (pending_notices.size() == 0 || pending_notices[$] !== rows[i].fixed)
          report_mismatch("table row prediction", i, 0);
      end else
        send_command(rows[i].cmd, rows[i].caller, rows[i].target, rows[i].priv,
                     rows[i].reg_ok);
    end
    drain();

    // fill the watch table to reach full, then a death that fills the exit table
    for (k = 0; k < TABLE_DEPTH + 2; k++)
      send_command(CMD_WATCH, ep_t'(1000 + k), 77, 1, 1);
    send_command(CMD_WAIT, 9, 9, 0, 1);
    send_command(CMD_SIGNAL, 0, 1000, 0, 0);
    send_command(CMD_DIED, 0, 77, 0, 0);
    for (k = 0; k < TABLE_DEPTH + 1; k++)
      send_command(CMD_WATCH, ep_t'(3000 + k), 78, 1, 1);
    send_command(CMD_DIED, 0, 78, 0, 0);
    send_command(CMD_QUERY, 1000, 0, 1, 1);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (k = 0; k < 15; k++) begin
        send_command(pick_cmd(), pick_ep(), pick_ep(), $urandom_range(9) != 0,
                     $urandom_range(9) != 0);
        if (k == 7) wait_empty();
      end
      drain();
    end

    done = 1'b1;
    drain();
    $display("covered %0d commands and %0d result transactions, incl. full tables",
             n_commands, n_results);
    if (n_errors == 0 && pending_notices.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
